### rtl/core/vfpd_pkg.sv
// Package for the voxel first-point downsampler: constants, codes and shared types.
// No dependencies; every other file of the block imports it.
`default_nettype none

package vfpd_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 4096;
    localparam int unsigned PROBE_LIMIT_DEF   = 8;

    localparam int unsigned COORD_W     = 32;
    localparam int unsigned INV_W       = 32;
    localparam int unsigned KEY_W       = 31;
    localparam int unsigned HASH_W      = 32;
    localparam int unsigned SLOT_W      = 20;
    localparam int unsigned EPOCH_W     = 4;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned CFG_IDX_W   = 2;

    // 100000 m in Q16.16.
    localparam logic [32:0] OFFSET_Q16 = 33'd6553600000;

    localparam logic [HASH_W-1:0] PRIME_X = 32'd73856093;
    localparam logic [HASH_W-1:0] PRIME_Y = 32'd19349663;
    localparam logic [HASH_W-1:0] PRIME_Z = 32'd83492791;

    localparam logic [INV_W-1:0] INV_RESET = 32'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_X,
        CFG_INV_Y,
        CFG_INV_Z
    } t_cfg_idx;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_KEY,
        F_HASH,
        F_XOR,
        F_MOD,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_CMP
    } t_back_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      cloud_end;
        logic [KEY_W-1:0]          kx;
        logic [KEY_W-1:0]          ky;
        logic [KEY_W-1:0]          kz;
        logic [HASH_W-1:0]         hash;
        logic [SLOT_W-1:0]         base;
    } t_job;

endpackage

`default_nettype wire

### rtl/core/vfpd_in_if.sv
// Input channel of the downsampler: valid/ready handshake and one point per item.
// Uses vfpd_pkg for the field widths.
`default_nettype none

interface vfpd_in_if;
    import vfpd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;
    logic                      cloud_end;

    modport source (output valid, output x_coord, output y_coord, output z_coord,
                    output cloud_end, input ready);
    modport sink (input valid, input x_coord, input y_coord, input z_coord,
                  input cloud_end, output ready);
endinterface

`default_nettype wire

### rtl/core/vfpd_out_if.sv
// Output channel of the downsampler: valid/ready handshake and one verdict per item.
// Uses vfpd_pkg for the field widths.
`default_nettype none

interface vfpd_out_if;
    import vfpd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;
    logic signed [COORD_W-1:0] z_out;
    logic                      keep;
    logic                      table_full;
    logic                      cloud_end_out;

    modport source (output valid, output x_out, output y_out, output z_out, output keep,
                    output table_full, output cloud_end_out, input ready);
    modport sink (input valid, input x_out, input y_out, input z_out, input keep,
                  input table_full, input cloud_end_out, output ready);
endinterface

`default_nettype wire

### rtl/core/vfpd_front.sv
// Front end: accepts a point, forms the three voxel keys, the hash and the base slot.
// Depends on vfpd_pkg and vfpd_in_if.
`default_nettype none

module vfpd_front import vfpd_pkg::*; #(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [INV_W-1:0] i_inv_x,
    input  wire logic [INV_W-1:0] i_inv_y,
    input  wire logic [INV_W-1:0] i_inv_z,
    input  wire logic             i_hold,
    vfpd_in_if.sink               in_ch,
    output logic                  o_push,
    output t_job                  o_job,
    input  wire logic             i_full
);

    localparam int unsigned IDX_W   = $clog2(TABLE_ENTRIES);
    localparam bit          POW2    = ((64'd1 << IDX_W) == 64'(TABLE_ENTRIES));
    localparam int unsigned Q_SHIFT = HASH_W + IDX_W;
    localparam logic [HASH_W-1:0] N_W = HASH_W'(TABLE_ENTRIES);
    localparam logic [32:0] RECIP =
        33'((64'd1 << (HASH_W + IDX_W)) / 64'(TABLE_ENTRIES));

    t_front_state r_state, n_state;

    logic signed [COORD_W-1:0] r_coord [3];
    logic                      r_end;
    logic [49:0]               r_pa [3];
    logic [49:0]               r_pb [3];
    logic [KEY_W-1:0]          r_key [3];
    logic [HASH_W-1:0]         r_hp [3];
    logic [HASH_W-1:0]         r_hash;
    logic [IDX_W-1:0]          r_rem;
    logic [1:0]                r_step;
    logic [48:0]               r_qa;
    logic [47:0]               r_qb;
    logic [HASH_W-1:0]         r_q;
    logic [HASH_W-1:0]         r_qn;

    logic [INV_W-1:0]  inv [3];
    logic [HASH_W-1:0] prime [3];
    logic [33:0]       sum [3];
    logic [KEY_W-1:0]  key [3];
    logic [64:0]       q_sum;
    logic [HASH_W-1:0] q_est;
    logic [HASH_W-1:0] mod_t;
    logic [IDX_W-1:0]  mod_r;

    always_comb begin
        logic [50:0] acc;
        logic [34:0] k35;
        inv[0]   = i_inv_x;
        inv[1]   = i_inv_y;
        inv[2]   = i_inv_z;
        prime[0] = PRIME_X;
        prime[1] = PRIME_Y;
        prime[2] = PRIME_Z;
        for (int a = 0; a < 3; a++) begin
            sum[a] = {{2{r_coord[a][COORD_W-1]}}, r_coord[a]} + {1'b0, OFFSET_Q16};
            acc    = {1'b0, r_pa[a]} + {17'd0, r_pb[a][49:16]};
            k35    = acc[50:16];
            key[a] = (k35[34:31] != 4'd0) ? {KEY_W{1'b1}} : k35[KEY_W-1:0];
        end
    end

    // Reduction of the hash by the table size through the reciprocal: the quotient
    // estimate is at most one short, so a single conditional subtraction finishes it.
    always_comb begin
        q_sum = {r_qa, 16'd0} + {17'd0, r_qb};
        q_est = HASH_W'(q_sum >> Q_SHIFT);
        mod_t = r_hash - r_qn;
        mod_r = (mod_t >= N_W) ? IDX_W'(mod_t - N_W) : mod_t[IDX_W-1:0];
    end

    assign in_ch.ready = (r_state == F_IDLE) && !i_hold;
    assign o_push      = (r_state == F_PUSH) && !i_full;

    always_comb begin
        o_job           = '0;
        o_job.x         = r_coord[0];
        o_job.y         = r_coord[1];
        o_job.z         = r_coord[2];
        o_job.cloud_end = r_end;
        o_job.kx        = r_key[0];
        o_job.ky        = r_key[1];
        o_job.kz        = r_key[2];
        o_job.hash      = r_hash;
        o_job.base      = SLOT_W'(r_rem);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (in_ch.valid && in_ch.ready) begin
                    n_state = F_MUL;
                end
            end
            F_MUL:  n_state = F_KEY;
            F_KEY:  n_state = F_HASH;
            F_HASH: n_state = F_XOR;
            F_XOR:  n_state = F_MOD;
            F_MOD: begin
                if (POW2 || (r_step == 2'd0)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) begin
            r_coord[0] <= in_ch.x_coord;
            r_coord[1] <= in_ch.y_coord;
            r_coord[2] <= in_ch.z_coord;
            r_end      <= in_ch.cloud_end;
        end
        for (int a = 0; a < 3; a++) begin
            if (r_state == F_MUL) begin
                r_pa[a] <= {16'd0, sum[a]} * {34'd0, inv[a][31:16]};
                r_pb[a] <= {16'd0, sum[a]} * {34'd0, inv[a][15:0]};
            end
            if (r_state == F_KEY) begin
                r_key[a] <= key[a];
            end
            if (r_state == F_HASH) begin
                r_hp[a] <= HASH_W'({1'b0, r_key[a]} * prime[a]);
            end
        end
        if (r_state == F_XOR) begin
            r_hash <= r_hp[0] ^ r_hp[1] ^ r_hp[2];
            r_step <= 2'd3;
            r_rem  <= '0;
        end
        if (r_state == F_MOD) begin
            if (POW2) begin
                r_rem <= r_hash[IDX_W-1:0];
            end else begin
                unique case (r_step)
                    2'd3: begin
                        r_qa <= {17'd0, r_hash} * {32'd0, RECIP[32:16]};
                        r_qb <= {16'd0, r_hash} * {32'd0, RECIP[15:0]};
                    end
                    2'd2: r_q   <= q_est;
                    2'd1: r_qn  <= r_q * N_W;
                    2'd0: r_rem <= mod_r;
                endcase
                r_step <= r_step - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/vfpd_queue.sv
// Short job queue between the front end and the table back end.
// Depends on vfpd_pkg for the job type and depth.
`default_nettype none

module vfpd_queue import vfpd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

endmodule

`default_nettype wire

### rtl/core/vfpd_back.sv
// Back end: probes the voxel key table, records new voxels and drives the result register.
// Depends on vfpd_pkg and vfpd_out_if.
`default_nettype none

module vfpd_back import vfpd_pkg::*; #(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int unsigned PROBE_LIMIT   = PROBE_LIMIT_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_job      i_job,
    input  wire logic i_empty,
    output logic      o_pop,
    output logic      o_clearing,
    vfpd_out_if.source out_ch
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned PW    = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
    localparam int unsigned ENT_W = EPOCH_W + 3 * KEY_W;

    t_back_state r_state, n_state;

    // Each entry holds its epoch tag and the three keys; an entry is in use only when
    // its tag equals the current epoch, so a new cloud needs no sweep unless the epoch wraps.
    logic [ENT_W-1:0]   r_mem [TABLE_ENTRIES];
    logic [ENT_W-1:0]   r_rdata;
    t_job               r_job;
    logic [IDX_W-1:0]   r_slot;
    logic [PW-1:0]      r_probe;
    logic [EPOCH_W-1:0] r_epoch;
    logic [IDX_W-1:0]   r_clr;

    logic                      r_out_valid;
    logic signed [COORD_W-1:0] r_x, r_y, r_z;
    logic                      r_keep, r_full, r_end;

    logic             slot_free, key_match, last_probe, finish, out_free, done;
    logic             w_en;
    logic [IDX_W-1:0] w_addr;
    logic [ENT_W-1:0] w_data;
    logic [IDX_W:0]   slot_inc;
    logic [IDX_W-1:0] slot_next;
    logic [HASH_W-1:0] hash_next;

    assign slot_free  = (r_rdata[ENT_W-1 -: EPOCH_W] != r_epoch);
    assign key_match  = (r_rdata[3*KEY_W-1:0] == {r_job.kx, r_job.ky, r_job.kz});
    assign last_probe = (r_probe == PW'(PROBE_LIMIT - 1));
    assign finish     = (r_state == B_CMP) && (slot_free || key_match || last_probe);
    assign out_free   = !r_out_valid || out_ch.ready;
    assign done       = finish && out_free;

    // The probe slot goes back to slot zero at the table end and when the 32-bit hash sum wraps.
    always_comb begin
        hash_next = r_job.hash + HASH_W'(r_probe) + 32'd1;
        slot_inc  = {1'b0, r_slot} + 1'b1;
        if (hash_next == '0 || slot_inc == (IDX_W+1)'(TABLE_ENTRIES)) begin
            slot_next = '0;
        end else begin
            slot_next = slot_inc[IDX_W-1:0];
        end
    end

    assign o_pop      = (r_state == B_IDLE) && !i_empty;
    assign o_clearing = (r_state == B_CLEAR);

    always_comb begin
        w_en   = 1'b0;
        w_addr = r_slot;
        w_data = {r_epoch, r_job.kx, r_job.ky, r_job.kz};
        if (r_state == B_CLEAR) begin
            w_en   = 1'b1;
            w_addr = r_clr;
            w_data = '0;
        end else if (done && slot_free) begin
            w_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rdata <= r_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: begin
                if (r_clr == IDX_W'(TABLE_ENTRIES - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_empty) begin
                    n_state = B_READ;
                end
            end
            B_READ: n_state = B_CMP;
            B_CMP: begin
                if (!finish) begin
                    n_state = B_READ;
                end else if (out_free) begin
                    if (r_job.cloud_end && (r_epoch == {EPOCH_W{1'b1}})) begin
                        n_state = B_CLEAR;
                    end else begin
                        n_state = B_IDLE;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_epoch     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == B_CLEAR) begin
                if (r_clr == IDX_W'(TABLE_ENTRIES - 1)) begin
                    r_clr   <= '0;
                    r_epoch <= EPOCH_W'(1);
                end else begin
                    r_clr <= r_clr + 1'b1;
                end
            end else if (done && r_job.cloud_end) begin
                r_epoch <= r_epoch + 1'b1;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job   <= i_job;
            r_slot  <= i_job.base[IDX_W-1:0];
            r_probe <= '0;
        end else if ((r_state == B_CMP) && !finish) begin
            r_slot  <= slot_next;
            r_probe <= r_probe + 1'b1;
        end
        if (done) begin
            r_x    <= r_job.x;
            r_y    <= r_job.y;
            r_z    <= r_job.z;
            r_keep <= slot_free || !key_match;
            r_full <= !slot_free && !key_match;
            r_end  <= r_job.cloud_end;
        end
    end

    assign out_ch.valid         = r_out_valid;
    assign out_ch.x_out         = r_x;
    assign out_ch.y_out         = r_y;
    assign out_ch.z_out         = r_z;
    assign out_ch.keep          = r_keep;
    assign out_ch.table_full    = r_full;
    assign out_ch.cloud_end_out = r_end;

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLEAR) |-> !o_pop)
        else $error("job taken during table clearing");

    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != B_CLEAR) |-> (r_epoch != '0))
        else $error("epoch zero outside clearing marks cleared entries as used");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && !out_free) |=> ((r_state == B_CMP) && $stable(r_slot)))
        else $error("verdict dropped while result register busy");

    a_clear_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == B_CLEAR) && (r_clr == IDX_W'(TABLE_ENTRIES - 1)))
        |=> ((r_state == B_IDLE) && (r_epoch == EPOCH_W'(1))))
        else $error("clearing pass did not restart the epoch");

endmodule

`default_nettype wire

### rtl/core/voxel_first_point_downsampler.sv
// Voxel-grid downsampler that keeps the first point of each voxel.
// Point items enter on in_ch (valid/ready) and leave one for one on out_ch, in arrival
// order, with keep, table_full and cloud_end_out attached. The three reciprocal voxel
// sizes are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write
// them only while the block is idle, which the block itself does not enforce. The front
// end takes one point at a time through its multiply, key, hash, XOR, modulo and push
// states; the modulo is a bit select when TABLE_ENTRIES is a power of two and a
// reciprocal reduction of the hash otherwise. A two-entry queue decouples it from the
// back end, which pops each job and then spends one registered memory read and one
// compare per table probe. After reset the back end sweeps the table, and in_ch.ready
// stays low meanwhile. The same sweep repeats after every fifteenth cloud end, when the
// four-bit table epoch wraps; other cloud ends clear the table at once.
// When the receiver stalls, the result register holds, the back end waits on its
// verdict, the queue fills and the front end drops ready.
// Depends on vfpd_pkg, vfpd_in_if, vfpd_out_if, vfpd_front, vfpd_queue and vfpd_back.
`default_nettype none

module voxel_first_point_downsampler import vfpd_pkg::*; #(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int unsigned PROBE_LIMIT   = PROBE_LIMIT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [INV_W-1:0]     i_cfg_data,
    vfpd_in_if.sink                   in_ch,
    vfpd_out_if.source                out_ch
);

    logic [INV_W-1:0] r_inv_x, r_inv_y, r_inv_z;

    logic push, full, pop, empty, clearing;
    t_job job_in, job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_x <= INV_RESET;
            r_inv_y <= INV_RESET;
            r_inv_z <= INV_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_INV_X: r_inv_x <= i_cfg_data;
                CFG_INV_Y: r_inv_y <= i_cfg_data;
                CFG_INV_Z: r_inv_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vfpd_front #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_inv_x (r_inv_x),
        .i_inv_y (r_inv_y),
        .i_inv_z (r_inv_z),
        .i_hold  (clearing),
        .in_ch   (in_ch),
        .o_push  (push),
        .o_job   (job_in),
        .i_full  (full)
    );

    vfpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_empty (empty)
    );

    vfpd_back #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .PROBE_LIMIT  (PROBE_LIMIT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (job_out),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_clearing (clearing),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire
